[rtl/core/dq_pkg.sv]
package dq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 5;
    localparam int COUNT_W   = 5;

    typedef enum logic [1:0] {
        CMD_INS_FRONT = 2'd0,
        CMD_INS_BACK  = 2'd1,
        CMD_DELETE    = 2'd2,
        CMD_DUMP      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2
    } t_status;

    // per-cell move select, load has priority over the shifts
    typedef struct packed {
        logic load;
        logic take_left;
        logic take_right;
    } t_cell_ctrl;

endpackage

[rtl/core/dq_if.sv]
interface dq_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       cmd;
    logic signed [dq_pkg::VALUE_W-1:0] value;
    logic [dq_pkg::POS_W-1:0]         position;

    modport source (output valid, cmd, value, position, input ready);
    modport sink   (input valid, cmd, value, position, output ready);
endinterface

interface dq_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [dq_pkg::VALUE_W-1:0] item_value;
    logic                             item_valid;
    logic                             last;
    logic [dq_pkg::COUNT_W-1:0]       count;
    logic [1:0]                       status;

    modport source (output valid, item_value, item_valid, last, count, status,
                    input ready);
    modport sink   (input valid, item_value, item_valid, last, count, status,
                    output ready);
endinterface

[rtl/core/dq_cell.sv]
module dq_cell (
    input  logic                              i_clk,
    input  dq_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [dq_pkg::VALUE_W-1:0] i_left,
    input  logic signed [dq_pkg::VALUE_W-1:0] i_right,
    input  logic signed [dq_pkg::VALUE_W-1:0] i_load,
    output logic signed [dq_pkg::VALUE_W-1:0] o_data
);

    logic signed [dq_pkg::VALUE_W-1:0] r_data;
    logic signed [dq_pkg::VALUE_W-1:0] n_data;

    always_comb begin
        if (i_ctrl.load) begin
            n_data = i_load;
        end else if (i_ctrl.take_left) begin
            n_data = i_left;
        end else if (i_ctrl.take_right) begin
            n_data = i_right;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[rtl/core/deque_with_positional_delete.sv]
// bounded deque of signed 32-bit entries held in a row of shift cells
// insert front / insert back / delete: result registered the next cycle after acceptance
// dump of n entries: one beat per cycle while beats are taken, through a left rotation of the row
// throughput: one command per cycle while results are taken, dump holds input for its beats
// reset (synchronous, i_rst_n low): queue empty, output beat dropped, cell contents left as is
module deque_with_positional_delete #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dq_cmd_if.sink     i_cmd,
    dq_res_if.source   o_res
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > dq_pkg::POS_W) ? CW : dq_pkg::POS_W;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    // control and count
    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx,   n_idx;

    // output beat register
    logic                              r_out_valid, n_out_valid;
    logic signed [dq_pkg::VALUE_W-1:0] r_item_value, n_item_value;
    logic                              r_item_valid, n_item_valid;
    logic                              r_last, n_last;
    logic [dq_pkg::COUNT_W-1:0]        r_count_out, n_count_out;
    dq_pkg::t_status                   r_status, n_status;

    // row of cells
    logic signed [dq_pkg::VALUE_W-1:0] w_cell_data [DEPTH];
    dq_pkg::t_cell_ctrl                w_cell_ctrl [DEPTH];
    logic signed [dq_pkg::VALUE_W-1:0] w_load_bus;

    logic            w_free;      // output slot empty or being drained
    logic            w_fire;
    logic            w_full;
    logic            w_do_front, w_do_back, w_do_del, w_do_rot;
    logic            w_pos_bad;
    logic [CMPW-1:0] w_pos_ext;
    logic [CMPW-1:0] w_count_ext;
    logic [CMPW-1:0] w_ncount_ext;
    logic            w_dump_last;

    assign w_free      = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && w_free;
    assign w_fire      = i_cmd.valid && i_cmd.ready;

    assign w_full      = (r_count == CW'(DEPTH));
    assign w_pos_ext   = CMPW'(i_cmd.position);
    assign w_count_ext = CMPW'(r_count);
    assign w_pos_bad   = (w_pos_ext == '0) || (w_pos_ext > w_count_ext);

    // edits of the row for accepted insert and delete commands
    assign w_do_front = w_fire && (i_cmd.cmd == dq_pkg::CMD_INS_FRONT) && !w_full;
    assign w_do_back  = w_fire && (i_cmd.cmd == dq_pkg::CMD_INS_BACK) && !w_full;
    assign w_do_del   = w_fire && (i_cmd.cmd == dq_pkg::CMD_DELETE) && !w_pos_bad;
    // dump: every beat reads cell 0 and rotates the held entries left by one,
    // so after count beats the row is back in its original order
    assign w_do_rot   = (r_state == S_DUMP) && w_free;

    assign w_dump_last = (r_idx == CW'(r_count - 1'b1));
    assign w_load_bus  = w_do_rot ? w_cell_data[0] : i_cmd.value;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [dq_pkg::VALUE_W-1:0] w_left;
            logic signed [dq_pkg::VALUE_W-1:0] w_right;

            if (gi == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_cell_data[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_end
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_cell_data[gi+1];
            end

            always_comb begin
                // front insert loads cell 0, back insert loads the first free cell,
                // rotation wraps cell 0 into the last held cell
                w_cell_ctrl[gi].load = (w_do_front && (gi == 0)) ||
                                       (w_do_back && (r_count == CW'(gi))) ||
                                       (w_do_rot && (r_count == CW'(gi + 1)));
                w_cell_ctrl[gi].take_left  = w_do_front && (gi != 0);
                // delete closes the gap from the deleted position onward
                w_cell_ctrl[gi].take_right = (w_do_del && (CMPW'(gi + 1) >= w_pos_ext)) ||
                                             w_do_rot;
            end

            dq_cell u_cell (
                .i_clk  (i_clk),
                .i_ctrl (w_cell_ctrl[gi]),
                .i_left (w_left),
                .i_right(w_right),
                .i_load (w_load_bus),
                .o_data (w_cell_data[gi])
            );
        end
    endgenerate

    // count reported on the beat, masked to the port width
    assign w_ncount_ext = CMPW'(n_count);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_item_value = r_item_value;
        n_item_valid = r_item_valid;
        n_last       = r_last;
        n_status     = r_status;

        case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    n_item_value = '0;
                    n_item_valid = 1'b0;
                    n_last       = 1'b1;
                    n_status     = dq_pkg::ST_OK;
                    n_out_valid  = 1'b1;
                    case (i_cmd.cmd)
                        dq_pkg::CMD_INS_FRONT, dq_pkg::CMD_INS_BACK: begin
                            if (w_full) begin
                                n_status = dq_pkg::ST_FULL;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        dq_pkg::CMD_DELETE: begin
                            if (w_pos_bad) begin
                                n_status = dq_pkg::ST_BADPOS;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        default: begin
                            // dump: empty queue gives a single marker beat
                            if (r_count != '0) begin
                                n_out_valid = 1'b0;
                                n_idx       = '0;
                                n_state     = S_DUMP;
                            end
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (w_free) begin
                    n_out_valid  = 1'b1;
                    n_item_value = w_cell_data[0];
                    n_item_valid = 1'b1;
                    n_last       = w_dump_last;
                    n_status     = dq_pkg::ST_OK;
                    n_idx        = r_idx + 1'b1;
                    if (w_dump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_count_out = w_ncount_ext[dq_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_item_value <= n_item_value;
        r_item_valid <= n_item_valid;
        r_last       <= n_last;
        r_count_out  <= n_count_out;
        r_status     <= n_status;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.item_value = r_item_value;
    assign o_res.item_valid = r_item_valid;
    assign o_res.last       = r_last;
    assign o_res.count      = r_count_out;
    assign o_res.status     = r_status;

endmodule
